[src/vcdg_pkg.sv]
// Shared types, register codes and arithmetic for the volume gradient core.
package vcdg_pkg;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int Z_WIDTH = 17;

   localparam logic [1:0] CSR_VOL_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_VOL_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_VOL_DEPTH  = 2'd2;

   typedef struct packed {
      logic [7:0] voxel;
      logic       filler;
   } req_payload_type;

   typedef struct packed {
      logic signed [7:0] grad_x;
      logic signed [7:0] grad_y;
      logic signed [7:0] grad_z;
      logic              last_voxel;
   } rsp_payload_type;

   typedef struct packed {
      logic hit;
      logic busy;
      logic load;
   } csr_status_type;

   typedef struct packed {
      logic [7:0] next_x;
      logic [7:0] prev_x;
      logic [7:0] next_y;
      logic [7:0] prev_y;
      logic [7:0] prev_z;
   } tap_type;

   function automatic logic signed [7:0] half_diff(input logic [7:0] nxt,
                                                  input logic [7:0] prv);
      logic signed [8:0] diff;
      logic signed [8:0] adj;
      diff = $signed({1'b0, nxt}) - $signed({1'b0, prv});
      adj  = diff + $signed({8'd0, diff[8]});
      return $signed(adj[8:1]);
   endfunction

endpackage

[src/vcdg_ram.sv]
// Generic one-write two-read RAM with registered read data.
module vcdg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

[src/vcdg_csr.sv]
// Configuration registers, clamped volume sizes and plane size.
module vcdg_csr #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1),
   localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [vcdg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output logic [WW-1:0]                      w_eff,
   output logic [HW-1:0]                      h_eff,
   output logic [15:0]                        d_eff,
   output logic [PW-1:0]                      plane,
   output vcdg_pkg::csr_status_type           status
);
   import vcdg_pkg::*;

   logic [8:0]       width_ff, width_in;
   logic [8:0]       height_ff, height_in;
   logic [15:0]      depth_ff, depth_in;
   logic [1:0]       settle_ff, settle_in;
   logic [PW-1:0]    plane_ff, plane_in;
   logic [WW+HW-1:0] product;
   logic             write_go;
   logic             hit;

   assign csr_ready = 1'b1;
   assign write_go  = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      hit       = 1'b0;
      if (write_go) begin
         unique case (csr_index)
            CSR_VOL_WIDTH: begin
               width_in = csr_wdata[8:0];
               hit      = 1'b1;
            end
            CSR_VOL_HEIGHT: begin
               height_in = csr_wdata[8:0];
               hit       = 1'b1;
            end
            CSR_VOL_DEPTH: begin
               depth_in = csr_wdata[15:0];
               hit      = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == 9'd0) begin
         w_eff = WW'(1);
      end else if (width_ff > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == 9'd0) begin
         h_eff = HW'(1);
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
      d_eff = (depth_ff == 16'd0) ? 16'd1 : depth_ff;
   end

   assign product  = w_eff * h_eff;
   assign plane_in = PW'(product);

   always_comb begin
      if (hit) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         depth_ff  <= 16'd256;
         settle_ff <= 2'd2;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
   end

   assign plane       = plane_ff;
   assign status.hit  = hit;
   assign status.busy = settle_ff != 2'd0;
   assign status.load = settle_ff == 2'd1;

endmodule

[src/vcdg_history.sv]
// Voxel history ring: pointers, two ring RAMs and the x-neighbour delay.
module vcdg_history #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
   input  logic              clock,
   input  logic              go,
   input  logic [7:0]        wr_voxel,
   input  logic              load,
   input  logic [PW-1:0]     plane,
   input  logic [WW-1:0]     w_eff,
   output vcdg_pkg::tap_type taps
);
   import vcdg_pkg::*;

   localparam int HistLen = 2 * MAX_WIDTH * MAX_HEIGHT + 1;
   localparam int AW = $clog2(HistLen);

   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] r_pm1_ff, r_pm1_in;
   logic [AW-1:0] r_pmw_ff, r_pmw_in;
   logic [AW-1:0] r_ppw_ff, r_ppw_in;
   logic [AW-1:0] r_2p_ff, r_2p_in;
   logic [AW-1:0] p_a, w_a;
   logic [7:0]    rd_pm1, rd_pmw, rd_ppw, rd_2p;
   logic [7:0]    hist1_ff, hist2_ff;

   function automatic logic [AW-1:0] start_ptr(input logic [AW-1:0] k);
      return (k == '0) ? '0 : AW'(HistLen) - k;
   endfunction

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
      return (ptr == AW'(HistLen - 1)) ? '0 : ptr + AW'(1);
   endfunction

   assign p_a = AW'(plane);
   assign w_a = AW'(w_eff);

   always_comb begin
      wp_in    = wp_ff;
      r_pm1_in = r_pm1_ff;
      r_pmw_in = r_pmw_ff;
      r_ppw_in = r_ppw_ff;
      r_2p_in  = r_2p_ff;
      if (load) begin
         wp_in    = '0;
         r_pm1_in = start_ptr(p_a - AW'(1));
         r_pmw_in = start_ptr(p_a - w_a);
         r_ppw_in = start_ptr(p_a + w_a);
         r_2p_in  = start_ptr(p_a + p_a);
      end else if (go) begin
         wp_in    = next_ptr(wp_ff);
         r_pm1_in = next_ptr(r_pm1_ff);
         r_pmw_in = next_ptr(r_pmw_ff);
         r_ppw_in = next_ptr(r_ppw_ff);
         r_2p_in  = next_ptr(r_2p_ff);
      end
   end

   always_ff @(posedge clock) begin
      wp_ff    <= wp_in;
      r_pm1_ff <= r_pm1_in;
      r_pmw_ff <= r_pmw_in;
      r_ppw_ff <= r_ppw_in;
      r_2p_ff  <= r_2p_in;
      if (go) begin
         hist1_ff <= rd_pm1;
         hist2_ff <= hist1_ff;
      end
   end

   vcdg_ram #(
      .WIDTH(8),
      .DEPTH(HistLen)
   ) u_ram_xy (
      .clock    (clock),
      .wr_en    (go),
      .wr_addr  (wp_ff),
      .wr_data  (wr_voxel),
      .rd_en    (go),
      .rd_addr_a(r_pm1_ff),
      .rd_addr_b(r_pmw_ff),
      .rd_data_a(rd_pm1),
      .rd_data_b(rd_pmw)
   );

   vcdg_ram #(
      .WIDTH(8),
      .DEPTH(HistLen)
   ) u_ram_yz (
      .clock    (clock),
      .wr_en    (go),
      .wr_addr  (wp_ff),
      .wr_data  (wr_voxel),
      .rd_en    (go),
      .rd_addr_a(r_ppw_ff),
      .rd_addr_b(r_2p_ff),
      .rd_data_a(rd_ppw),
      .rd_data_b(rd_2p)
   );

   assign taps.next_x = rd_pm1;
   assign taps.prev_x = hist2_ff;
   assign taps.next_y = rd_pmw;
   assign taps.prev_y = rd_ppw;
   assign taps.prev_z = rd_2p;

endmodule

[src/volume_central_difference_gradient_core.sv]
// Top level of the streaming central-difference volume gradient core.
// Takes one voxel per cycle while req_stall is low, in raster order, and
// returns, one plane later, the halved x, y and z differences of the centred
// voxel (zero on every face). Each result goes through the stencil stage and
// result registers, and W*H+W+1 filler transfers after the volume drain it.
// History lives in two ring RAMs of 2*MAX_WIDTH*MAX_HEIGHT+1 bytes, each with
// one write and two reads per cycle, which sets the rate of one item a cycle.
// After reset and after each register write the input is stalled while the
// plane size and the ring read pointers load.
module volume_central_difference_gradient_core #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  vcdg_pkg::req_payload_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output vcdg_pkg::rsp_payload_type          rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [vcdg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import vcdg_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

   logic [WW-1:0]      w_eff;
   logic [HW-1:0]      h_eff;
   logic [15:0]        d_eff;
   logic [PW-1:0]      plane;
   csr_status_type     status;
   tap_type            taps;

   logic [WW-1:0]      x_ff, x_in;
   logic [HW-1:0]      y_ff, y_in;
   logic [Z_WIDTH-1:0] z_ff, z_in;
   logic [Z_WIDTH-1:0] d_ext;
   logic               end_item;
   logic               zero_item;
   logic [7:0]         wr_voxel;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_res_ff, s1_inside_ff, s1_last_ff;
   logic [7:0]         s1_next_z_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_result;

   logic               rsp_free;
   logic               s1_go;
   logic               req_go;

   vcdg_csr #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .w_eff    (w_eff),
      .h_eff    (h_eff),
      .d_eff    (d_eff),
      .plane    (plane),
      .status   (status)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && rsp_free;
   assign req_stall = status.busy || (s1_valid_ff && !rsp_free);
   assign req_go    = req_valid && !req_stall;

   assign d_ext     = {1'b0, d_eff};
   assign zero_item = req_data.filler || (z_ff >= d_ext);
   assign wr_voxel  = zero_item ? 8'd0 : req_data.voxel;

   always_comb begin
      if (h_eff != HW'(1)) begin
         end_item = (z_ff == d_ext + Z_WIDTH'(1)) && (y_ff == HW'(1)) && (x_ff == '0);
      end else begin
         end_item = (z_ff == d_ext + Z_WIDTH'(2)) && (y_ff == '0) && (x_ff == '0);
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (status.hit) begin
         x_in = '0;
         y_in = '0;
         z_in = '0;
      end else if (req_go) begin
         if (end_item) begin
            x_in = '0;
            y_in = '0;
            z_in = '0;
         end else if (x_ff == w_eff - WW'(1)) begin
            x_in = '0;
            if (y_ff == h_eff - HW'(1)) begin
               y_in = '0;
               z_in = z_ff + Z_WIDTH'(1);
            end else begin
               y_in = y_ff + HW'(1);
            end
         end else begin
            x_in = x_ff + WW'(1);
         end
      end
   end

   vcdg_history #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_history (
      .clock   (clock),
      .go      (req_go),
      .wr_voxel(wr_voxel),
      .load    (status.load),
      .plane   (plane),
      .w_eff   (w_eff),
      .taps    (taps)
   );

   always_comb begin
      if (req_go) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_go) begin
         rsp_valid_in = s1_res_ff;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      rsp_result.grad_x     = '0;
      rsp_result.grad_y     = '0;
      rsp_result.grad_z     = '0;
      rsp_result.last_voxel = s1_last_ff;
      if (s1_inside_ff) begin
         rsp_result.grad_x = half_diff(taps.next_x, taps.prev_x);
         rsp_result.grad_y = half_diff(taps.next_y, taps.prev_y);
         rsp_result.grad_z = half_diff(s1_next_z_ff, taps.prev_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_res_ff    <= (z_ff != '0) && (z_ff <= d_ext);
         s1_inside_ff <= (x_ff != '0) && (x_ff < w_eff - WW'(1)) &&
                         (y_ff != '0) && (y_ff < h_eff - HW'(1)) &&
                         (z_ff >= Z_WIDTH'(2)) && (z_ff < d_ext);
         s1_last_ff   <= (z_ff == d_ext) && (x_ff == w_eff - WW'(1)) &&
                         (y_ff == h_eff - HW'(1));
         s1_next_z_ff <= wr_voxel;
      end
      if (s1_go && s1_res_ff) begin
         rsp_data_ff <= rsp_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_hit_holds_input: assert property (@(posedge clock) disable iff (reset)
      status.hit |=> status.busy)
      else $error("register write not followed by input hold");

   a_x_in_range: assert property (@(posedge clock) disable iff (reset)
      x_ff < w_eff)
      else $error("column counter beyond volume width");

   a_y_in_range: assert property (@(posedge clock) disable iff (reset)
      y_ff < h_eff)
      else $error("row counter beyond plane height");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_free) |=> (s1_valid_ff && $stable(s1_next_z_ff)))
      else $error("stencil stage lost while result stalled");

endmodule
